// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ORL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ORL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/orl_pkg.sv -----
// Package with types, constants and command codes of the ordered list engine.
`default_nettype none
package orl_pkg;
	localparam int ENTRIES  = 1024;
	localparam int KEY_BITS = 16;
	localparam int IDX_W    = $clog2(ENTRIES);

	localparam logic [2:0] REQ_INSERT  = 3'd0;
	localparam logic [2:0] REQ_REMOVE  = 3'd1;
	localparam logic [2:0] REQ_UP      = 3'd2;
	localparam logic [2:0] REQ_DOWN    = 3'd3;
	localparam logic [2:0] REQ_UP_IF   = 3'd4;
	localparam logic [2:0] REQ_DOWN_IF = 3'd5;
	localparam logic [2:0] REQ_SET_KEY = 3'd6;
	localparam logic [2:0] REQ_NOP     = 3'd7;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MEMBER  = 2'd1;
	localparam logic [1:0] ST_ABSENT  = 2'd2;

	typedef struct packed {
		logic [2:0]          req_type;
		logic [IDX_W-1:0]    entry_index;
		logic [KEY_BITS-1:0] key_value;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             moved;
		logic [IDX_W-1:0] top_index;
		logic [IDX_W-1:0] bottom_index;
		logic             list_empty;
	} rsp_t;

	// Datapath commands issued by the controller.
	typedef struct packed {
		logic clear;      // clear one membership flag after reset
		logic load;       // capture request
		logic rd_self;    // read links and key of the entry
		logic rd_nbr;     // read links and key of the neighbor
		logic exec;       // perform the update
		logic respond;    // drive result
	} cmd_t;

	// Datapath status returned to the controller.
	typedef struct packed {
		logic clr_last;   // clearing pass is at the last entry
	} sts_t;
endpackage
`default_nettype wire

// ----- rtl/ordered_reap_list_engine_unit.sv -----
// Ordered list engine top level: controller plus datapath.
// Usage: raise start with a request on req; it transfers when busy is low.
// The block then runs a fixed sequence: a read of the entry (RD1), a read of
// its neighbor in the link and key memories (RD2), three write beats (WR0,
// WR1, WR2) on the single-port link memories, then the result state (RSP).
// Busy is low again in the cycle after the result cycle, so the block takes
// no new request until it has given the result of the last one; the
// single-port link memories set this.
// The result rsp is valid for exactly one cycle while done is high; the
// receiver cannot stall it and must take it then.
// Reset clears the ends and sets the empty flag immediately, then a clearing
// pass zeroes all 1024 membership flags while busy stays high.
// Link and key contents are undefined until written.
`default_nettype none
module ordered_reap_list_engine_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire orl_pkg::req_t req,
	output logic               busy,
	output logic               done,
	output orl_pkg::rsp_t      rsp
);
	orl_pkg::cmd_t cmd;
	orl_pkg::sts_t sts;

	orl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .busy(busy), .done(done),
		.cmd(cmd));

	orl_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req_in(req), .rsp_out(rsp), .sts(sts));
endmodule
`default_nettype wire

// ----- rtl/orl_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module orl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Registered read; a write to the same address returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ----- rtl/orl_datapath.sv -----
// Datapath of the ordered list engine: link, key and member stores, end registers.
`default_nettype none
`include "assert_macros.svh"
module orl_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire orl_pkg::cmd_t cmd,
	input  wire orl_pkg::req_t req_in,
	output orl_pkg::rsp_t      rsp_out,
	output orl_pkg::sts_t      sts
);
	localparam int IW = orl_pkg::IDX_W;
	localparam int KW = orl_pkg::KEY_BITS;

	orl_pkg::req_t    req_q;
	logic [1:0]       status_q;
	logic             moved_q;
	logic [IW-1:0]    top_q, bot_q;
	logic             empty_q;
	logic             self_mem_q;
	logic [IW-1:0]    clr_addr_q;
	logic [IW-1:0]    self_prev_q, self_next_q;
	logic [IW-1:0]    nbr_prev_q, nbr_next_q;
	logic [KW-1:0]    nbr_key_q;

	// RAM ports: write-only phase uses a sequence of writes.
	logic             nx_we, pv_we, ky_we, mb_we;
	logic [IW-1:0]    nx_a, pv_a, ky_a, mb_a;
	logic [IW-1:0]    nx_wd, pv_wd;
	logic [KW-1:0]    ky_wd;
	logic             mb_wd;
	logic [IW-1:0]    nx_rd, pv_rd;
	logic [KW-1:0]    ky_rd;
	logic             mb_rd;

	orl_ram #(.WIDTH(IW), .DEPTH(orl_pkg::ENTRIES)) u_next (
		.clk(clk), .we(nx_we), .addr(nx_a), .wdata(nx_wd), .rdata(nx_rd));
	orl_ram #(.WIDTH(IW), .DEPTH(orl_pkg::ENTRIES)) u_prev (
		.clk(clk), .we(pv_we), .addr(pv_a), .wdata(pv_wd), .rdata(pv_rd));
	orl_ram #(.WIDTH(KW), .DEPTH(orl_pkg::ENTRIES)) u_key (
		.clk(clk), .we(ky_we), .addr(ky_a), .wdata(ky_wd), .rdata(ky_rd));
	orl_ram #(.WIDTH(1), .DEPTH(orl_pkg::ENTRIES)) u_member (
		.clk(clk), .we(mb_we), .addr(mb_a), .wdata(mb_wd), .rdata(mb_rd));

	logic [IW-1:0] e;
	logic          is_top, is_bot, is_mem, up_dir, go;
	logic [IW-1:0] x, p, pp, n;
	logic          p_top, x_bot;

	// Neighbor read data is taken straight from the RAMs in the first write beat.
	logic          nbr_live;
	logic [IW-1:0] nbr_prev, nbr_next;
	logic [KW-1:0] nbr_key;

	// Write sequencer over up to three write beats; step counter.
	logic [1:0] wstep_q;

	assign e      = req_q.entry_index;
	assign is_top = (top_q == e);
	assign is_bot = (bot_q == e);
	assign is_mem = self_mem_q;
	assign up_dir = (req_q.req_type == orl_pkg::REQ_UP) ||
		(req_q.req_type == orl_pkg::REQ_UP_IF);

	assign nbr_live = cmd.exec && (wstep_q == 2'd0);
	assign nbr_prev = nbr_live ? pv_rd : nbr_prev_q;
	assign nbr_next = nbr_live ? nx_rd : nbr_next_q;
	assign nbr_key  = nbr_live ? ky_rd : nbr_key_q;

	// Decide whether the swap happens and which entry moves up.
	always_comb begin
		go = 1'b0;
		if (up_dir) begin
			go = !is_top && ((req_q.req_type == orl_pkg::REQ_UP) ||
				(req_q.key_value >= nbr_key));
		end else begin
			go = !is_bot && ((req_q.req_type == orl_pkg::REQ_DOWN) ||
				(req_q.key_value <= nbr_key));
		end
		// x moves above p; pp above p, n below x
		if (up_dir) begin
			x  = e;
			p  = self_prev_q;
			pp = nbr_prev;
			n  = self_next_q;
		end else begin
			x  = self_next_q;
			p  = e;
			pp = self_prev_q;
			n  = nbr_next;
		end
		p_top = (top_q == p);
		x_bot = (bot_q == x);
	end

	logic valid_op, is_move;
	assign valid_op = is_mem && (req_q.req_type != orl_pkg::REQ_INSERT) &&
		(req_q.req_type != orl_pkg::REQ_SET_KEY) && (req_q.req_type != orl_pkg::REQ_NOP);
	assign is_move = valid_op && (req_q.req_type != orl_pkg::REQ_REMOVE);

	// RAM address and write control per phase.
	always_comb begin
		nx_we = 1'b0; pv_we = 1'b0; ky_we = 1'b0;
		nx_a = e; pv_a = e; ky_a = e;
		nx_wd = '0; pv_wd = '0; ky_wd = req_q.key_value;
		if (cmd.rd_nbr) begin
			nx_a = up_dir ? pv_rd : nx_rd;
			pv_a = nx_a;
			ky_a = nx_a;
		end else if (cmd.exec) begin
			case (wstep_q)
				2'd0: begin
					if (req_q.req_type == orl_pkg::REQ_INSERT) begin
						ky_we = !is_mem;
						pv_we = !is_mem && !empty_q;
						pv_wd = bot_q;
						nx_we = !is_mem && !empty_q;
						nx_a  = bot_q;
						nx_wd = e;
					end else if (req_q.req_type == orl_pkg::REQ_SET_KEY) begin
						ky_we = 1'b1;
					end else if (req_q.req_type == orl_pkg::REQ_REMOVE) begin
						nx_we = is_mem && !is_top;
						nx_a  = self_prev_q;
						nx_wd = is_bot ? e : self_next_q;
						pv_we = is_mem && !is_top && !is_bot;
						pv_a  = self_next_q;
						pv_wd = self_prev_q;
					end else if (is_move) begin
						// Conditional moves store the new key.
						ky_we = (req_q.req_type == orl_pkg::REQ_UP_IF) ||
							(req_q.req_type == orl_pkg::REQ_DOWN_IF);
						nx_we = go && !p_top;
						nx_a  = pp;
						nx_wd = x;
						pv_we = go && !x_bot;
						pv_a  = n;
						pv_wd = p;
					end
				end
				2'd1: begin
					nx_we = is_move && go;
					nx_a  = x;
					nx_wd = p;
					pv_we = is_move && go;
					pv_a  = p;
					pv_wd = x;
				end
				default: begin
					nx_we = is_move && go && !x_bot;
					nx_a  = p;
					nx_wd = n;
					pv_we = is_move && go && !p_top;
					pv_a  = x;
					pv_wd = pp;
				end
			endcase
		end
	end

	// Membership flags: cleared entry by entry after reset, updated in the last write beat.
	always_comb begin
		mb_we = 1'b0;
		mb_a  = e;
		mb_wd = 1'b0;
		if (cmd.clear) begin
			mb_we = 1'b1;
			mb_a  = clr_addr_q;
		end else if (cmd.exec && wstep_q == 2'd2) begin
			if (req_q.req_type == orl_pkg::REQ_INSERT) begin
				mb_we = !is_mem;
				mb_wd = 1'b1;
			end else if (req_q.req_type == orl_pkg::REQ_REMOVE) begin
				mb_we = is_mem;
			end
		end
	end

	// Clearing pass address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + IW'(1);
		end
	end

	assign sts.clr_last = (clr_addr_q == IW'(orl_pkg::ENTRIES - 1));

	// Request capture, read capture and write step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wstep_q <= '0;
		end else if (cmd.exec) begin
			wstep_q <= wstep_q + 2'd1;
		end else begin
			wstep_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_in;
		end
		if (cmd.rd_nbr) begin
			self_prev_q <= pv_rd;
			self_next_q <= nx_rd;
			self_mem_q  <= mb_rd;
		end
		if (cmd.exec && wstep_q == 2'd0) begin
			nbr_prev_q <= pv_rd;
			nbr_next_q <= nx_rd;
			nbr_key_q  <= ky_rd;
		end
	end

	// Control registers: ends, result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= '0;
			bot_q    <= '0;
			empty_q  <= 1'b1;
			status_q <= orl_pkg::ST_OK;
			moved_q  <= 1'b0;
		end else if (cmd.exec && wstep_q == 2'd2) begin
			status_q <= orl_pkg::ST_OK;
			moved_q  <= 1'b0;
			case (req_q.req_type)
				orl_pkg::REQ_NOP, orl_pkg::REQ_SET_KEY: begin
				end
				orl_pkg::REQ_INSERT: begin
					if (is_mem) begin
						status_q <= orl_pkg::ST_MEMBER;
					end else begin
						if (empty_q) begin
							top_q   <= e;
							empty_q <= 1'b0;
						end
						bot_q <= e;
					end
				end
				orl_pkg::REQ_REMOVE: begin
					if (!is_mem) begin
						status_q <= orl_pkg::ST_ABSENT;
					end else begin
						if (is_top && is_bot) begin
							empty_q <= 1'b1;
							top_q   <= '0;
							bot_q   <= '0;
						end else if (is_top) begin
							top_q <= self_next_q;
						end else if (is_bot) begin
							bot_q <= self_prev_q;
						end
					end
				end
				default: begin
					if (!is_mem) begin
						status_q <= orl_pkg::ST_ABSENT;
					end else if (go) begin
						moved_q <= 1'b1;
						if (p_top) top_q <= x;
						if (x_bot) bot_q <= p;
					end
				end
			endcase
		end
	end

	assign rsp_out.status       = status_q;
	assign rsp_out.moved        = moved_q;
	assign rsp_out.top_index    = empty_q ? '0 : top_q;
	assign rsp_out.bottom_index = empty_q ? '0 : bot_q;
	assign rsp_out.list_empty   = empty_q;

	`ORL_ASSERT_IMP(a_empty_ends, clk, arst_n, empty_q, (top_q == '0) && (bot_q == '0),
		"empty list with nonzero ends")
	`ORL_ASSERT_IMP(a_moved_ok, clk, arst_n, moved_q, status_q == orl_pkg::ST_OK,
		"moved with error status")
	`ORL_ASSERT_IMP(a_status_code, clk, arst_n, 1'b1, (status_q == orl_pkg::ST_OK) || (status_q == orl_pkg::ST_MEMBER) || (status_q == orl_pkg::ST_ABSENT),
		"unknown status code")
endmodule
`default_nettype wire

// ----- rtl/orl_ctrl.sv -----
// Controller state machine sequencing reads, writes and the result strobe.
`default_nettype none
`include "assert_macros.svh"
module orl_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire orl_pkg::sts_t sts,
	output logic               busy,
	output logic               done,
	output orl_pkg::cmd_t      cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD1  = 3'd1;
	localparam logic [2:0] S_RD2  = 3'd2;
	localparam logic [2:0] S_WR0  = 3'd3;
	localparam logic [2:0] S_WR1  = 3'd4;
	localparam logic [2:0] S_WR2  = 3'd5;
	localparam logic [2:0] S_RSP  = 3'd6;
	localparam logic [2:0] S_CLR  = 3'd7;

	logic [2:0] state_q, state_d;

	// Next state.
	always_comb begin
		case (state_q)
			S_CLR:   state_d = sts.clr_last ? S_IDLE : S_CLR;
			S_IDLE:  state_d = start ? S_RD1 : S_IDLE;
			S_RD1:   state_d = S_RD2;
			S_RD2:   state_d = S_WR0;
			S_WR0:   state_d = S_WR1;
			S_WR1:   state_d = S_WR2;
			S_WR2:   state_d = S_RSP;
			default: state_d = S_IDLE;
		endcase
	end

	// Reset starts the clearing pass over the membership flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands: RD1 addresses the entry, RD2 latches it and addresses the neighbor.
	assign cmd.clear   = (state_q == S_CLR);
	assign cmd.load    = (state_q == S_IDLE) && start;
	assign cmd.rd_self = (state_q == S_RD1);
	assign cmd.rd_nbr  = (state_q == S_RD2);
	assign cmd.exec    = (state_q == S_WR0) || (state_q == S_WR1) || (state_q == S_WR2);
	assign cmd.respond = (state_q == S_RSP);
	assign busy = (state_q != S_IDLE);
	assign done = cmd.respond;

	`ORL_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy,
		"accepted transfer did not raise busy")
	`ORL_ASSERT_NXT(a_done_idle, clk, arst_n, done, !busy, "not idle after result")
	`ORL_ASSERT_IMP(a_one_cmd, clk, arst_n, 1'b1,
		$onehot0({cmd.clear, cmd.rd_self, cmd.rd_nbr, cmd.exec, cmd.respond}),
		"overlapping commands")
endmodule
`default_nettype wire
